[rtl/srab_pkg.sv]
// Shared types and constants for the sized RAM access block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srab_pkg;

    localparam int MEM_BYTES_DEF = 65536;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 64;
    localparam int MEM_SIZE_W    = 17;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_READ  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_CAS   = 2'd2;
    localparam t_kind KIND_NOP   = 2'd3;

    typedef logic [1:0] t_size;
    localparam t_size SIZE_1 = 2'd0;
    localparam t_size SIZE_2 = 2'd1;
    localparam t_size SIZE_4 = 2'd2;
    localparam t_size SIZE_8 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_RDRAIN,
        S_WRITE,
        S_CAS_RD,
        S_CAS_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic rd_step;
        logic wr_step;
        logic cas_read;
        logic cas_write;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic  in_nop;
        logic  in_oob;
        logic  in_reduce;
        t_kind in_kind;
        t_kind reg_kind;
        logic  red_last;
        logic  last_byte;
    } t_stat;

endpackage

`default_nettype wire

[rtl/srab_ctrl.sv]
// Controller for the sized RAM access block: sequences one request at a time.
// Depends on srab_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module srab_ctrl
    import srab_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    function automatic t_state kind_state(input t_kind kind);
        t_state s;
        unique case (kind)
            KIND_READ:  s = S_READ;
            KIND_WRITE: s = S_WRITE;
            KIND_CAS:   s = S_CAS_RD;
            default:    s = S_FINISH;
        endcase
        return s;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    priority if (i_stat.in_nop || i_stat.in_oob) begin
                        n_state = S_FINISH;
                    end else if (i_stat.in_reduce) begin
                        n_state = S_REDUCE;
                    end else begin
                        n_state = kind_state(i_stat.in_kind);
                    end
                end
            end
            S_REDUCE: begin
                if (i_stat.red_last) begin
                    n_state = kind_state(i_stat.reg_kind);
                end
            end
            S_READ: begin
                if (i_stat.last_byte) begin
                    n_state = S_RDRAIN;
                end
            end
            S_RDRAIN: n_state = S_IDLE;
            S_WRITE: begin
                if (i_stat.last_byte) begin
                    n_state = S_FINISH;
                end
            end
            S_CAS_RD: n_state = S_CAS_WR;
            S_CAS_WR: n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   o_cmd.load      = i_start;
            S_REDUCE: o_cmd.reduce    = 1'b1;
            S_READ:   o_cmd.rd_step   = 1'b1;
            S_RDRAIN: o_cmd.finish    = 1'b1;
            S_WRITE:  o_cmd.wr_step   = 1'b1;
            S_CAS_RD: o_cmd.cas_read  = 1'b1;
            S_CAS_WR: o_cmd.cas_write = 1'b1;
            S_FINISH: o_cmd.finish    = 1'b1;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/srab_dp.sv]
// Datapath for the sized RAM access block: byte store, address reduction,
// byte lane assembly and result registers. Depends on srab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srab_dp
    import srab_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [MEM_SIZE_W-1:0] i_cfg_wdata,
    input  wire t_kind                 i_kind,
    input  wire t_size                 i_size_code,
    input  wire logic [ADDR_W-1:0]     i_address,
    input  wire logic [DATA_W-1:0]     i_write_data,
    input  wire logic [7:0]            i_expected_byte,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic                       o_done,
    output logic [DATA_W-1:0]          o_read_data,
    output logic                       o_status
);

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int CW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int STEPS = (AW >= ADDR_W + 1) ? 1 : (ADDR_W + 1 - AW);
    localparam int KW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [7:0] mem [MEM_BYTES];

    logic [MEM_SIZE_W-1:0] r_mem_size;
    t_kind                 r_kind;
    logic [2:0]            r_count_m1;
    logic [2:0]            r_byte_no;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_rem;
    logic [KW-1:0]         r_k;
    logic [DATA_W-1:0]     r_wdata;
    logic [7:0]            r_expect;
    logic [DATA_W-1:0]     r_rdata;
    logic                  r_req_status;
    logic [7:0]            r_mem_q;
    logic                  r_rd_vld;
    logic [2:0]            r_rd_lane;
    logic                  r_done;
    logic [DATA_W-1:0]     r_read_data;
    logic                  r_status;

    logic [CW-1:0]     shifted;
    logic [CW-1:0]     rem_next;
    logic [AW-1:0]     idx_inc;
    logic [DATA_W-1:0] n_rdata;
    logic [2:0]        in_count_m1;
    logic              in_reduce;
    logic              mem_we;

    assign in_reduce = (CW'(i_address) >= CW'(MEM_BYTES));
    assign shifted   = CW'(MEM_BYTES) << r_k;
    assign rem_next  = (r_rem >= shifted) ? (r_rem - shifted) : r_rem;
    assign idx_inc   = (r_idx == AW'(MEM_BYTES - 1)) ? '0 : (r_idx + AW'(1));
    assign n_rdata   = r_rd_vld ? (r_rdata | (DATA_W'(r_mem_q) << {r_rd_lane, 3'b000}))
                                : r_rdata;
    assign mem_we    = i_cmd.wr_step || (i_cmd.cas_write && (r_mem_q == r_expect));

    always_comb begin
        unique case (i_size_code)
            SIZE_1:  in_count_m1 = 3'd0;
            SIZE_2:  in_count_m1 = 3'd1;
            SIZE_4:  in_count_m1 = 3'd3;
            SIZE_8:  in_count_m1 = 3'd7;
            default: in_count_m1 = 3'd0;
        endcase
    end

    always_comb begin
        o_stat.in_nop    = (i_kind == KIND_NOP);
        o_stat.in_oob    = ({1'b0, i_address} >= r_mem_size);
        o_stat.in_reduce = in_reduce;
        o_stat.in_kind   = i_kind;
        o_stat.reg_kind  = r_kind;
        o_stat.red_last  = (r_k == '0);
        o_stat.last_byte = (r_byte_no == r_count_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.rd_step;
            r_done   <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_count_m1   <= in_count_m1;
            r_byte_no    <= '0;
            r_rem        <= CW'(i_address);
            r_k          <= KW'(STEPS - 1);
            r_wdata      <= i_write_data;
            r_expect     <= i_expected_byte;
            r_req_status <= (i_kind != KIND_NOP) && ({1'b0, i_address} >= r_mem_size);
            if (!in_reduce) begin
                r_idx <= AW'(i_address);
            end
        end
        if (i_cmd.reduce) begin
            r_rem <= rem_next;
            r_k   <= r_k - KW'(1);
            if (r_k == '0) begin
                r_idx <= AW'(rem_next);
            end
        end
        if (i_cmd.rd_step || i_cmd.wr_step) begin
            r_idx     <= idx_inc;
            r_byte_no <= r_byte_no + 3'd1;
        end
        if (i_cmd.rd_step) begin
            r_rd_lane <= r_byte_no;
        end
        // advance the write data so the current byte sits in the low lane
        if (i_cmd.wr_step) begin
            r_wdata <= r_wdata >> 8;
        end
        if (i_cmd.load) begin
            r_rdata <= '0;
        end else if (r_rd_vld) begin
            r_rdata <= n_rdata;
        end
        if (i_cmd.finish) begin
            r_read_data <= n_rdata;
            r_status    <= r_req_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= r_wdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_step || i_cmd.cas_read) begin
            r_mem_q <= mem[r_idx];
        end
    end

    assign o_done      = r_done;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

`default_nettype wire

[rtl/sized_ram_access_with_bounds_unit.sv]
// Top level of the sized RAM access block: byte-addressable store with a
// start-address bounds check. Depends on srab_pkg, srab_ctrl and srab_dp.
//
// A request is taken when i_start is high and o_busy is low; its result shows
// on o_read_data and o_status for exactly one cycle with o_done high, and the
// receiver cannot stall it. The store is a single-port memory one byte wide,
// so a request touches its bytes one at a time: a read or write of N bytes
// (N = 1, 2, 4 or 8) steps through N bytes, a compare-and-swap reads and may
// write one byte, and an out-of-bounds request or the unused kind touches
// none. A start address at or above MEM_BYTES is first reduced, one reduction
// step per cycle. Write i_cfg_wdata with i_cfg_we only while the block is
// idle; every access is out of bounds until it is set.
`timescale 1ns / 1ps
`default_nettype none

module sized_ram_access_with_bounds_unit
    import srab_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [MEM_SIZE_W-1:0] i_cfg_wdata,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [1:0]            i_kind,
    input  wire logic [1:0]            i_size_code,
    input  wire logic [ADDR_W-1:0]     i_address,
    input  wire logic [DATA_W-1:0]     i_write_data,
    input  wire logic [7:0]            i_expected_byte,
    output logic                       o_done,
    output logic [DATA_W-1:0]          o_read_data,
    output logic                       o_status
);

    t_cmd  cmd;
    t_stat stat;

    srab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    srab_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_size_code     (i_size_code),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_expected_byte (i_expected_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire
